// ----- rtl/bfd_pkg.sv -----
// bfd_pkg: shared types and constants of the bounded frame descriptor fifo
// holds opcodes, drop codes, config register indexes and field widths
// no dependencies
`default_nettype none

package bfd_pkg;

  localparam int OP_W        = 2;
  localparam int WORD_W      = 32;
  localparam int LEVEL_W     = 5;
  localparam int CODE_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_CLR = 2'd2
  } bfd_op_e;

  typedef enum logic [CODE_W-1:0] {
    DROP_NONE     = 2'd0,
    DROP_INCOMING = 2'd1,
    DROP_OLD      = 2'd2
  } bfd_drop_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMIT_EN   = 2'd0,
    CFG_FILL_LIMIT = 2'd1,
    CFG_TAIL_DROP  = 2'd2
  } bfd_cfg_idx_e;

  localparam logic               LIMIT_EN_RST   = 1'b1;
  localparam logic [LEVEL_W-1:0] FILL_LIMIT_RST = 5'd16;
  localparam logic               TAIL_DROP_RST  = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/bfd_ctrl.sv -----
// bfd_ctrl: handshake controller of the bounded frame descriptor fifo
// decides when an operation executes and when the result register is valid
// depends on no other file
`default_nettype none

module bfd_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire logic deq_hit_i,
  output logic      exec_o
);

  typedef enum logic {
    S_IDLE,
    S_WAIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  // a new operation goes in when no read is pending and the result slot is empty or drains this cycle
  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign exec_o      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (exec_o) begin
            if (deq_hit_i) begin
              // memory read data lands next cycle
              state_q     <= S_WAIT;
              out_valid_q <= 1'b0;
            end else begin
              out_valid_q <= 1'b1;
            end
          end else if (out_valid_q && out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        S_WAIT: begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b1;
        end
        default: begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_wait_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WAIT |-> !out_valid_q)
    else $error("result valid while read data is pending");

  a_wait_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WAIT |=> state_q == S_IDLE && out_valid_q)
    else $error("read wait did not complete in one cycle");

  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_o && !deq_hit_i |=> out_valid_q && state_q == S_IDLE)
    else $error("executed operation produced no result");

  a_no_exec_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WAIT |-> !exec_o)
    else $error("operation accepted during read wait");
`endif

endmodule

`default_nettype wire

// ----- rtl/bfd_datapath.sv -----
// bfd_datapath: word store, head/tail pointers, fill count, config registers
// and the result register of the bounded frame descriptor fifo
// depends on bfd_pkg
`default_nettype none

module bfd_datapath #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bfd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [bfd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                          exec_i,
  input  wire logic [bfd_pkg::OP_W-1:0]      op_i,
  input  wire logic [bfd_pkg::WORD_W-1:0]    word_i,
  output logic                               deq_hit_o,
  output logic                               res_valid_o,
  output logic [bfd_pkg::WORD_W-1:0]         res_word_o,
  output logic [bfd_pkg::LEVEL_W-1:0]        res_level_o,
  output logic [bfd_pkg::CODE_W-1:0]         res_code_o
);

  import bfd_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > LEVEL_W) ? CW : LEVEL_W;
  localparam int SW = (WORD_BITS < WORD_W) ? WORD_BITS : WORD_W;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx);
    advance = (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  logic [SW-1:0] mem [DEPTH];
  logic [SW-1:0] rdata_q;

  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;

  logic               lim_en_q, tail_drop_q;
  logic [LEVEL_W-1:0] fill_lim_q;

  logic               res_valid_q, res_valid_d;
  logic [LEVEL_W-1:0] res_level_q;
  bfd_drop_e          res_code_q, res_code_d;

  logic [LW-1:0] eff_limit;
  logic [LW-1:0] count_ext_d;
  logic          at_limit;
  logic          wr_en;
  bfd_op_e       op;

  assign op = bfd_op_e'(op_i);

  always_comb begin
    if (lim_en_q && (LW'(fill_lim_q) < LW'(DEPTH))) begin
      eff_limit = LW'(fill_lim_q);
    end else begin
      eff_limit = LW'(DEPTH);
    end
  end

  assign at_limit = LW'(count_q) >= eff_limit;

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    wr_en       = 1'b0;
    deq_hit_o   = 1'b0;
    res_valid_d = 1'b0;
    res_code_d  = DROP_NONE;
    case (op)
      OP_ENQ: begin
        if (at_limit) begin
          if (tail_drop_q || eff_limit == '0 || count_q == '0) begin
            res_code_d = DROP_INCOMING;
          end else begin
            // head drop: oldest leaves, new word enters, level unchanged
            wr_en      = 1'b1;
            head_d     = advance(head_q);
            tail_d     = advance(tail_q);
            res_code_d = DROP_OLD;
          end
        end else begin
          wr_en   = 1'b1;
          tail_d  = advance(tail_q);
          count_d = count_q + 1'b1;
        end
      end
      OP_DEQ: begin
        if (count_q != '0) begin
          deq_hit_o   = 1'b1;
          res_valid_d = 1'b1;
          head_d      = advance(head_q);
          count_d     = count_q - 1'b1;
        end
      end
      OP_CLR: begin
        head_d  = '0;
        tail_d  = '0;
        count_d = '0;
      end
      default: ;
    endcase
  end

  assign count_ext_d = LW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      lim_en_q    <= LIMIT_EN_RST;
      fill_lim_q  <= FILL_LIMIT_RST;
      tail_drop_q <= TAIL_DROP_RST;
    end else begin
      if (exec_i) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
      end
      if (cfg_we_i) begin
        case (bfd_cfg_idx_e'(cfg_index_i))
          CFG_LIMIT_EN:   lim_en_q    <= cfg_data_i[0];
          CFG_FILL_LIMIT: fill_lim_q  <= cfg_data_i;
          CFG_TAIL_DROP:  tail_drop_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // result register, payload only
  always_ff @(posedge clk_i) begin
    if (exec_i) begin
      res_valid_q <= res_valid_d;
      res_level_q <= count_ext_d[LEVEL_W-1:0];
      res_code_q  <= res_code_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_i && wr_en) begin
      mem[tail_q] <= word_i[SW-1:0];
    end
    if (exec_i && deq_hit_o) begin
      rdata_q <= mem[head_q];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_word_o  = res_valid_q ? WORD_W'(rdata_q) : '0;
  assign res_level_o = res_level_q;
  assign res_code_o  = res_code_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count exceeds depth");

  a_deq_decrements: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_i && deq_hit_o |=> count_q == $past(count_q) - 1'b1)
    else $error("dequeue did not lower the fill count");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_i && op == OP_CLR |=> count_q == '0 && head_q == '0 && tail_q == '0)
    else $error("clear left words in the queue");

  a_head_drop_keeps_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_i && res_code_d == DROP_OLD |=> $stable(count_q) && count_q != '0)
    else $error("head drop changed the fill count");
`endif

endmodule

`default_nettype wire

// ----- rtl/bounded_fifo_with_drop_policy.sv -----
// a result is valid in the cycle after its operation is accepted, except for a
// dequeue that returns a word, which first waits in S_WAIT for the registered store read
// throughput: one operation per cycle while results are taken, none while a dequeue waits in S_WAIT
// a waiting result does not block the next operation if it is taken that cycle
// reset: pointers and fill count clear, config registers load their defaults,
// store contents stay undefined until written
`default_nettype none

module bounded_fifo_with_drop_policy #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // config write channel
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [bfd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [bfd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // operation stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [bfd_pkg::WORD_W-1:0]         s_axis_tdata,  // frame_word
  input  wire logic [bfd_pkg::OP_W-1:0]           s_axis_tuser,  // opcode
  // result stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [bfd_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,  // word_out, fill_level, drop_code, pad
  output logic                                    m_axis_tuser   // word_valid
);

  import bfd_pkg::*;

  logic               exec;
  logic               deq_hit;
  logic               res_valid;
  logic [WORD_W-1:0]  res_word;
  logic [LEVEL_W-1:0] res_level;
  logic [CODE_W-1:0]  res_code;

  assign cfg_ready_o = 1'b1;

  bfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .deq_hit_i   (deq_hit),
    .exec_o      (exec)
  );

  bfd_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .exec_i      (exec),
    .op_i        (s_axis_tuser),
    .word_i      (s_axis_tdata),
    .deq_hit_o   (deq_hit),
    .res_valid_o (res_valid),
    .res_word_o  (res_word),
    .res_level_o (res_level),
    .res_code_o  (res_code)
  );

  assign m_axis_tdata = {1'b0, res_code, res_level, res_word};
  assign m_axis_tuser = res_valid;

endmodule

`default_nettype wire
